[hw/rtl/byte_stream_tokenizer_macros.svh]
// Assertion macros for the byte stream tokenizer.
`ifndef BYTE_STREAM_TOKENIZER_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define BST_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define BST_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define BST_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/bst_pkg.sv]
// Shared types, constants and lookup functions of the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

	localparam int POS_WIDTH_DEF     = 32;
	localparam int KEYWORD_CHARS_DEF = 7;

	localparam int LEN_W        = 16;
	localparam int START_W      = 32;
	localparam int KW_COUNT     = 10;
	localparam int KW_TEXT_W    = 56;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = QPTR_W + 1;
	localparam int OUT_DATA_W   = 56;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// Byte codes with a meaning of their own
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5a;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_PIPE   = 8'h7c;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	typedef enum logic [4:0] {
		TK_EOF      = 5'd0,
		TK_NUMBER   = 5'd1,
		TK_ID       = 5'd2,
		TK_KW_INT   = 5'd3,
		TK_KW_BOOL  = 5'd4,
		TK_KW_TRUE  = 5'd5,
		TK_KW_FALSE = 5'd6,
		TK_KW_IF    = 5'd7,
		TK_KW_ELSE  = 5'd8,
		TK_KW_MATCH = 5'd9,
		TK_KW_CASE  = 5'd10,
		TK_KW_DEF   = 5'd11,
		TK_KW_PRINT = 5'd12,
		TK_EQEQ     = 5'd13,
		TK_NE       = 5'd14,
		TK_ANDAND   = 5'd15,
		TK_OROR     = 5'd16,
		TK_ASSIGN   = 5'd17,
		TK_LT       = 5'd18,
		TK_GT       = 5'd19,
		TK_PLUS     = 5'd20,
		TK_SEMI     = 5'd21,
		TK_COLON    = 5'd22,
		TK_LPAREN   = 5'd23,
		TK_RPAREN   = 5'd24,
		TK_LBRACE   = 5'd25,
		TK_RBRACE   = 5'd26,
		TK_UNKNOWN  = 5'd27
	} tok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_EQ,
		MODE_BANG,
		MODE_AMP,
		MODE_PIPE
	} scan_mode_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic               last;
	} tok_t;

	// Up to two tokens per source byte; a lone token always rides lane 0
	typedef struct packed {
		logic v0;
		tok_t t0;
		logic v1;
		tok_t t1;
	} tok_push_t;

	typedef struct packed {
		logic              room;
		logic              nonempty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	// Keyword spellings, first character in the lowest byte, zero padded
	localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
		56'h00_0000_0074_6e69,
		56'h00_0000_6c6f_6f62,
		56'h00_0000_6575_7274,
		56'h00_0065_736c_6166,
		56'h00_0000_0000_6669,
		56'h00_0000_6573_6c65,
		56'h00_0068_6374_616d,
		56'h00_0000_6573_6163,
		56'h74_6c75_6166_6564,
		56'h00_0074_6e69_7270
	};
	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		16'd3, 16'd4, 16'd4, 16'd5, 16'd2, 16'd4, 16'd5, 16'd4, 16'd7, 16'd5
	};
	localparam tok_kind_t KW_KIND [KW_COUNT] = '{
		TK_KW_INT, TK_KW_BOOL, TK_KW_TRUE, TK_KW_FALSE, TK_KW_IF,
		TK_KW_ELSE, TK_KW_MATCH, TK_KW_CASE, TK_KW_DEF, TK_KW_PRINT
	};

	// Prefix bytes past the lexeme length are zero, so a full compare works
	function automatic tok_kind_t kw_kind(input logic [KW_TEXT_W-1:0] text,
			input logic [LEN_W-1:0] len);
		tok_kind_t k;
		k = TK_ID;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
				k = KW_KIND[i];
			end
		end
		return k;
	endfunction

	function automatic tok_kind_t single_kind(input logic [7:0] b);
		tok_kind_t k;
		case (b)
			CH_LT:     k = TK_LT;
			CH_GT:     k = TK_GT;
			CH_PLUS:   k = TK_PLUS;
			CH_SEMI:   k = TK_SEMI;
			CH_COLON:  k = TK_COLON;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			default:   k = TK_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/byte_stream_tokenizer.sv]
// Top level of the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_tokenizer_macros.svh"
// Streaming lexer: takes one source byte per cycle on the slave side while
// the token queue has room and returns tokens (kind, start offset, saturating
// length) on the master side, one word per cycle while the receiver is ready.
// Byte 0 ends the source, flushes any held token, emits EOF and restarts
// offsets at 0. A token whose end needs the following byte is emitted when
// that byte arrives, so a byte gives zero, one or two tokens; tlast marks the
// final token of a byte. Scanner and output register are joined by a
// four-entry token queue, and the scanner takes a byte whenever at least two
// entries are free, so bytes enter at up to one per cycle while tokens leave
// at most one per cycle. The first token of a byte is presented after it passes
// the queue and the output register; a second token of the same byte follows it.
module byte_stream_tokenizer #(
	parameter int POS_WIDTH     = bst_pkg::POS_WIDTH_DEF,
	parameter int KEYWORD_CHARS = bst_pkg::KEYWORD_CHARS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] source_byte
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [4:0] token_kind, [36:5] start_pos, [52:37] token_length, [55:53] zero
	output logic [bst_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tlast
);
	import bst_pkg::*;

	tok_push_t push;
	q_stat_t   q_stat;
	tok_t      head;
	logic      pop;

	bst_front #(
		.POS_WIDTH     (POS_WIDTH),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_data  (s_axis_tdata),
		.byte_ready (s_axis_tready),
		.q_stat     (q_stat),
		.push       (push)
	);

	bst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	bst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.tok_valid (m_axis_tvalid),
		.tok_ready (m_axis_tready),
		.tok_data  (m_axis_tdata),
		.tok_last  (m_axis_tlast)
	);

	`BST_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "token queue overfilled")
	`BST_ASSERT_IMPL(a_eof_len, m_axis_tvalid && m_axis_tdata[4:0] == 5'(TK_EOF), m_axis_tdata[52:37] == '0 && m_axis_tlast, "EOF word with nonzero length or not last")
	`BST_ASSERT_IMPL(a_pair_len, m_axis_tvalid && (m_axis_tdata[4:0] == 5'(TK_EQEQ) || m_axis_tdata[4:0] == 5'(TK_NE) || m_axis_tdata[4:0] == 5'(TK_ANDAND) || m_axis_tdata[4:0] == 5'(TK_OROR)), m_axis_tdata[52:37] == LEN_W'(2) && m_axis_tlast, "two-byte operator word malformed")
	`BST_ASSERT_NEXT(a_eof_queued, s_axis_tvalid && s_axis_tready && s_axis_tdata == CH_NUL, q_stat.nonempty, "end of source left no token queued")

endmodule
`default_nettype wire

[hw/rtl/bst_front.sv]
// Scanner front end: takes source bytes, tracks the lexing mode, emits tokens.
`timescale 1ns / 1ps
`default_nettype none
module bst_front #(
	parameter int POS_WIDTH     = bst_pkg::POS_WIDTH_DEF,
	parameter int KEYWORD_CHARS = bst_pkg::KEYWORD_CHARS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	input  wire logic [7:0]          byte_data,
	output logic                     byte_ready,
	input  wire bst_pkg::q_stat_t    q_stat,
	output bst_pkg::tok_push_t       push
);
	import bst_pkg::*;

	localparam int PREFIX_W = KEYWORD_CHARS * 8;

	scan_mode_t            mode_q, mode_d;
	logic [POS_WIDTH-1:0]  pos_q, pos_d;
	logic [POS_WIDTH-1:0]  start_q, start_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [PREFIX_W-1:0]   prefix_q, prefix_d;

	logic                  accept;
	logic                  is_space, is_digit, is_alpha, is_op, op_mode;
	logic                  cont, paired, fresh;
	logic [7:0]            want;
	logic                  held_v, new_v;
	tok_t                  held_tok, new_tok;
	logic [63:0]           start_wide, pos_wide;
	logic [LEN_W-1:0]      len_grown;

	assign byte_ready = q_stat.room;
	assign accept     = byte_valid && q_stat.room;

	assign is_space = (byte_data == CH_SPACE) || (byte_data >= CH_TAB && byte_data <= CH_CR);
	assign is_digit = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
	assign is_alpha = (byte_data >= CH_LC_A && byte_data <= CH_LC_Z) ||
		(byte_data >= CH_UC_A && byte_data <= CH_UC_Z);
	assign is_op    = (byte_data == CH_EQ) || (byte_data == CH_BANG) ||
		(byte_data == CH_AMP) || (byte_data == CH_PIPE);
	assign op_mode  = mode_q inside {MODE_EQ, MODE_BANG, MODE_AMP, MODE_PIPE};

	assign want = (mode_q == MODE_AMP) ? CH_AMP : (mode_q == MODE_PIPE) ? CH_PIPE : CH_EQ;

	assign cont   = (mode_q == MODE_NUM && is_digit) ||
		(mode_q == MODE_IDENT && (is_digit || is_alpha));
	assign paired = op_mode && (byte_data == want);
	assign fresh  = !cont && !paired;

	assign start_wide = 64'(start_q);
	assign pos_wide   = 64'(pos_q);
	assign len_grown  = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);

	// Next scan mode
	always_comb begin
		mode_d = mode_q;
		if (accept && !cont) begin
			if (paired) begin
				mode_d = MODE_IDLE;
			end else if (is_digit) begin
				mode_d = MODE_NUM;
			end else if (is_alpha) begin
				mode_d = MODE_IDENT;
			end else if (byte_data == CH_EQ) begin
				mode_d = MODE_EQ;
			end else if (byte_data == CH_BANG) begin
				mode_d = MODE_BANG;
			end else if (byte_data == CH_AMP) begin
				mode_d = MODE_AMP;
			end else if (byte_data == CH_PIPE) begin
				mode_d = MODE_PIPE;
			end else begin
				mode_d = MODE_IDLE;
			end
		end
	end

	// Tokens and run registers
	always_comb begin
		held_v         = (mode_q != MODE_IDLE) && !cont;
		held_tok.kind  = TK_UNKNOWN;
		held_tok.start = start_wide[START_W-1:0];
		held_tok.len   = paired ? LEN_W'(2) : (op_mode ? LEN_W'(1) : len_q);
		held_tok.last  = 1'b0;
		unique case (mode_q)
			MODE_IDLE:  held_tok.kind = TK_UNKNOWN;
			MODE_NUM:   held_tok.kind = TK_NUMBER;
			MODE_IDENT: held_tok.kind = kw_kind(prefix_q[KW_TEXT_W-1:0], len_q);
			MODE_EQ:    held_tok.kind = paired ? TK_EQEQ : TK_ASSIGN;
			MODE_BANG:  held_tok.kind = paired ? TK_NE : TK_UNKNOWN;
			MODE_AMP:   held_tok.kind = paired ? TK_ANDAND : TK_UNKNOWN;
			MODE_PIPE:  held_tok.kind = paired ? TK_OROR : TK_UNKNOWN;
			default:    held_tok.kind = TK_UNKNOWN;
		endcase

		new_v         = fresh && !is_space && !is_digit && !is_alpha && !is_op;
		new_tok.kind  = (byte_data == CH_NUL) ? TK_EOF : single_kind(byte_data);
		new_tok.start = pos_wide[START_W-1:0];
		new_tok.len   = (byte_data == CH_NUL) ? LEN_W'(0) : LEN_W'(1);
		new_tok.last  = 1'b1;

		push.v0 = accept && (held_v || new_v);
		push.v1 = accept && held_v && new_v;
		push.t0 = held_v ? held_tok : new_tok;
		push.t1 = new_tok;
		push.t0.last = !(held_v && new_v);

		pos_d    = pos_q;
		start_d  = start_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		if (accept) begin
			pos_d = pos_q + POS_WIDTH'(1);
			if (cont) begin
				len_d = len_grown;
				if (mode_q == MODE_IDENT) begin
					for (int i = 0; i < KEYWORD_CHARS; i++) begin
						if (len_q == LEN_W'(i)) begin
							prefix_d[i*8 +: 8] = byte_data;
						end
					end
				end
			end else if (!paired) begin
				if (byte_data == CH_NUL) begin
					pos_d = '0;
				end
				if (is_digit || is_alpha || is_op) begin
					start_d = pos_q;
					len_d   = LEN_W'(1);
				end
				if (is_alpha) begin
					prefix_d = PREFIX_W'(byte_data);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bst_queue.sv]
// Token queue with two write lanes and one read port between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bst_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bst_pkg::tok_push_t  push,
	input  wire logic                pop,
	output bst_pkg::tok_t            head,
	output bst_pkg::q_stat_t         q_stat
);
	import bst_pkg::*;

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] n_push;
	logic              do_pop;

	assign n_push = QCNT_W'(push.v0) + QCNT_W'(push.v1);
	assign do_pop = pop && (cnt_q != '0);

	assign head            = mem_q[rd_q];
	assign q_stat.count    = cnt_q;
	assign q_stat.nonempty = (cnt_q != '0);
	// Keep two slots free so a byte that closes a run and makes a token fits
	assign q_stat.room     = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.t0;
		end
		if (push.v1) begin
			mem_q[wr_q + QPTR_W'(1)] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[QPTR_W-1:0];
			rd_q  <= rd_q + QPTR_W'(do_pop);
			cnt_q <= cnt_q + n_push - QCNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bst_back.sv]
// Output stage: pulls tokens from the queue into the master-side register.
`timescale 1ns / 1ps
`default_nettype none
module bst_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bst_pkg::tok_t                 head,
	input  wire bst_pkg::q_stat_t              q_stat,
	output logic                               pop,
	output logic                               tok_valid,
	input  wire logic                          tok_ready,
	output logic [bst_pkg::OUT_DATA_W-1:0]     tok_data,
	output logic                               tok_last
);
	import bst_pkg::*;

	logic valid_q;
	tok_t tok_q;

	// Load a new word when the register is empty or its word leaves now
	assign pop = q_stat.nonempty && (!valid_q || tok_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || tok_ready) begin
			valid_q <= q_stat.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= head;
		end
	end

	assign tok_valid = valid_q;
	assign tok_last  = tok_q.last;
	assign tok_data  = OUT_DATA_W'({tok_q.len, tok_q.start, 5'(tok_q.kind)});

endmodule
`default_nettype wire
